// File: sv/sitwl_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sorted interval table
// no dependencies; used by sitwl_cell and the top level
package sitwl_pkg;

    localparam int DATA_W   = 64;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // one stored half-open range [base, limit)
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] limit;
    } range_t;

endpackage

// File: sv/sitwl_cell.sv
`timescale 1ns / 1ps
// one cell of the range chain: holds a single range, loads from its neighbor
// depends on sitwl_pkg (range_t)
module sitwl_cell
(
    input  logic             clk,
    input  logic             en,
    input  sitwl_pkg::range_t d,
    output sitwl_pkg::range_t q
);

    sitwl_pkg::range_t range_reg;

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            range_reg <= d;
        end
    end

    assign q = range_reg;

endmodule

// File: sv/sorted_interval_table_with_lookup.sv
`timescale 1ns / 1ps
// top level of the sorted interval table with containment lookup
// depends on sitwl_pkg and sitwl_cell
//
// usage
//   a word is accepted at a rising edge with start high and busy low; kind,
//   addr, page_count and byte_length are sampled there
//   every word gives exactly one result word, shown for one cycle with done
//   high: status, covered and stored_ranges (count after the word)
//   the receiver cannot stall; done is a one-cycle strobe
// steps per word; busy drops in the done cycle, so a new word is only taken
// once the previous one has given its result
//   clear or unused kind       : result straight from idle
//   append, error or new range : check, then result
//   append extending last range: check, update of the newest range, then result
//   query, zero length/overflow: prep, then result
//   query                      : prep, one full rotation of the chain, then result
// the ranges live in a chain of MAX_RANGES cells, newest range in cell 0;
// a new range shifts the whole chain by one cell; a query rotates the chain
// through one full turn past a single compare point at cell 0, so its time
// is set by the chain length
// reset clears the range count and the control; cell contents need no reset
// since only cells below the count are ever compared
module sorted_interval_table_with_lookup
#(
    parameter int MAX_RANGES = 256,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [sitwl_pkg::KIND_W-1:0]          kind,
    input  logic [sitwl_pkg::DATA_W-1:0]          addr,
    input  logic [sitwl_pkg::DATA_W-1:0]          page_count,
    input  logic [sitwl_pkg::DATA_W-1:0]          byte_length,
    output logic                                  done,
    output logic [sitwl_pkg::STATUS_W-1:0]        status,
    output logic                                  covered,
    output logic [$clog2(MAX_RANGES+1)-1:0]       stored_ranges
);

    localparam int CW    = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int DW    = sitwl_pkg::DATA_W;

    localparam logic [DW-1:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

    // control states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_APP_CHK = 3'd1;
    localparam logic [2:0] S_APP_UPD = 3'd2;
    localparam logic [2:0] S_Q_PREP  = 3'd3;
    localparam logic [2:0] S_Q_RUN   = 3'd4;

    logic [2:0]                       state_reg,  state_next;
    logic [DW-1:0]                    addr_reg,   addr_next;
    logic [DW-1:0]                    arg_reg,    arg_next;
    logic [DW-1:0]                    end_reg,    end_next;
    logic [CW-1:0]                    step_reg,   step_next;
    logic [CW-1:0]                    pos_reg,    pos_next;
    logic                             hit_reg,    hit_next;
    logic [CNT_W-1:0]                 total_reg,  total_next;
    logic                             done_reg,   done_next;
    logic [sitwl_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                             covered_reg, covered_next;

    // chain control
    logic              shift_en;
    logic              rot_en;
    logic              ext_en;
    sitwl_pkg::range_t head_d;
    sitwl_pkg::range_t cell_q [MAX_RANGES];

    // append checks
    logic [DW-1:0] app_end;
    logic          app_bad;
    logic          has_last;
    // query span
    logic [DW:0]   q_sum;
    logic          q_bad;
    logic          q_match;

    assign app_end  = addr_reg + (arg_reg << PAGE_SHIFT);
    assign app_bad  = (arg_reg == '0) || ((addr_reg & PAGE_MASK) != '0)
                      || (arg_reg > ((~addr_reg) >> PAGE_SHIFT));
    assign has_last = (total_reg != '0);
    assign q_sum    = {1'b0, addr_reg} + {1'b0, arg_reg};
    assign q_bad    = (arg_reg == '0) || q_sum[DW];
    // end_reg holds the span end while a query runs
    assign q_match  = (CNT_W'(pos_reg) < total_reg) && (cell_q[0].base <= addr_reg)
                      && (cell_q[0].limit >= end_reg);

    // cell 0 input: wrap-around on rotation, new range on shift, grown end otherwise
    always_comb
    begin
        if (rot_en)
        begin
            head_d = cell_q[MAX_RANGES-1];
        end
        else if (shift_en)
        begin
            head_d.base  = addr_reg;
            head_d.limit = app_end;
        end
        else
        begin
            head_d.base  = cell_q[0].base;
            head_d.limit = end_reg;
        end
    end

    // the cell chain
    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            sitwl_cell u_cell
            (
                .clk (clk),
                .en  (shift_en | rot_en | ext_en),
                .d   (head_d),
                .q   (cell_q[0])
            );
        end
        else
        begin : g_body
            sitwl_cell u_cell
            (
                .clk (clk),
                .en  (shift_en | rot_en),
                .d   (cell_q[i-1]),
                .q   (cell_q[i])
            );
        end
    end

    // control
    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        arg_next     = arg_reg;
        end_next     = end_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        covered_next = covered_reg;
        shift_en     = 1'b0;
        rot_en       = 1'b0;
        ext_en       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    addr_next = addr;
                    unique case (kind)
                        sitwl_pkg::KIND_CLEAR:
                        begin
                            total_next   = '0;
                            done_next    = 1'b1;
                            status_next  = sitwl_pkg::ST_OK;
                            covered_next = 1'b0;
                        end
                        sitwl_pkg::KIND_APPEND:
                        begin
                            arg_next   = page_count;
                            state_next = S_APP_CHK;
                        end
                        sitwl_pkg::KIND_QUERY:
                        begin
                            arg_next   = byte_length;
                            state_next = S_Q_PREP;
                        end
                        default:
                        begin
                            done_next    = 1'b1;
                            status_next  = sitwl_pkg::ST_INVALID;
                            covered_next = 1'b0;
                        end
                    endcase
                end
            end
            S_APP_CHK:
            begin
                covered_next = 1'b0;
                state_next   = S_IDLE;
                done_next    = 1'b1;
                if (app_bad)
                begin
                    status_next = sitwl_pkg::ST_INVALID;
                end
                else if (has_last && (addr_reg < cell_q[0].base))
                begin
                    status_next = sitwl_pkg::ST_ORDER;
                end
                else if (has_last && (addr_reg <= cell_q[0].limit))
                begin
                    // touches or overlaps the newest range
                    end_next   = app_end;
                    done_next  = 1'b0;
                    state_next = S_APP_UPD;
                end
                else if (total_reg >= CNT_W'(MAX_RANGES))
                begin
                    status_next = sitwl_pkg::ST_FULL;
                end
                else
                begin
                    shift_en    = 1'b1;
                    total_next  = total_reg + CNT_W'(1);
                    status_next = sitwl_pkg::ST_OK;
                end
            end
            S_APP_UPD:
            begin
                ext_en      = (end_reg > cell_q[0].limit);
                status_next = sitwl_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_Q_PREP:
            begin
                status_next = sitwl_pkg::ST_OK;
                if (q_bad)
                begin
                    covered_next = 1'b0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    end_next   = q_sum[DW-1:0];
                    step_next  = '0;
                    pos_next   = '0;
                    hit_next   = 1'b0;
                    state_next = S_Q_RUN;
                end
            end
            S_Q_RUN:
            begin
                rot_en    = 1'b1;
                hit_next  = hit_reg | q_match;
                step_next = step_reg + CW'(1);
                // cell index now at the compare point, counting down with wrap
                pos_next  = (pos_reg == '0) ? CW'(MAX_RANGES - 1) : pos_reg - CW'(1);
                if (step_reg == CW'(MAX_RANGES - 1))
                begin
                    covered_next = hit_reg | q_match;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            done_reg    <= 1'b0;
            status_reg  <= sitwl_pkg::ST_OK;
            covered_reg <= 1'b0;
            hit_reg     <= 1'b0;
            step_reg    <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            covered_reg <= covered_next;
            hit_reg     <= hit_next;
            step_reg    <= step_next;
            pos_reg     <= pos_next;
        end
    end

    // item payload, no reset
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        arg_reg  <= arg_next;
        end_reg  <= end_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign covered       = covered_reg;
    assign stored_ranges = total_reg;

    // a result follows an accepted word or the end of a multi-cycle word
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(start) && ($past(state_reg) == S_IDLE))
                     || ($past(state_reg) != S_IDLE))
        else $error("result without a word in flight");

    // covered only comes out of a full query rotation, with status ok
    a_covered_query: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && covered_reg) |-> ($past(state_reg) == S_Q_RUN)
                                      && (status_reg == sitwl_pkg::ST_OK))
        else $error("covered set outside a query result");

    // the range count moves only together with a result
    a_total_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(total_reg) |-> done_reg)
        else $error("range count changed without a result");

    // the count never passes the chain length
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APP_CHK) |=> (total_reg <= CNT_W'(MAX_RANGES)))
        else $error("range count beyond chain length");

endmodule
